// ===== rtl/core/slpt_pkg.sv =====
// Shared constants and helpers for the stage latency percentile tracker.
package slpt_pkg;

    localparam int CAPACITY   = 256;
    localparam int NUM_STAGES = 8;

    localparam int TS_W     = 64;
    localparam int ACT_W    = 2;
    localparam int STAGE_W  = 3;
    localparam int METRIC_W = 2;
    localparam int PSEL_W   = 2;
    localparam int FRAMES_W = 9;

    localparam int CAP_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int STG_W     = $clog2(NUM_STAGES);
    localparam int RING_D    = CAPACITY * NUM_STAGES;
    localparam int RING_AW   = $clog2(RING_D);
    localparam int NUM_KINDS = 4;
    localparam int BUF_D     = NUM_KINDS * CAPACITY;
    localparam int BUF_AW    = $clog2(BUF_D);

    localparam int PCT_W   = 7;
    localparam int X_W     = CNT_W + PCT_W;
    localparam int RECIP_S = 26;
    localparam int RECIP_W = 20;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_S) + 99) / 100);

    localparam logic [ACT_W-1:0] ACT_LATCH  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_COMMIT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

    localparam logic [PSEL_W-1:0] PSEL_P50  = 2'd0;
    localparam logic [PSEL_W-1:0] PSEL_P95  = 2'd1;
    localparam logic [PSEL_W-1:0] PSEL_P99  = 2'd2;
    localparam logic [METRIC_W-1:0] MET_TOTAL = 2'd3;

    function automatic logic [PCT_W-1:0] pct_of(input logic [PSEL_W-1:0] p);
        logic [PCT_W-1:0] v;
        unique case (p)
            PSEL_P50: v = 7'd50;
            PSEL_P95: v = 7'd95;
            PSEL_P99: v = 7'd99;
            default:  v = 7'd99;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/slpt_ram.sv =====
// Generic single write port RAM with one registered read port.
module slpt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/stage_latency_percentile_tracker_unit.sv =====
// Top level of the stage latency percentile tracker: latches, record ring and query sequencer.
// A latch transfer stores its timestamp in the stage's latch; a commit writes the NUM_STAGES
// latches to the ring, one ring word per cycle. A query with n valid records first walks the
// ring record by record, building a latency list per kind, then finds each of the twelve
// percentiles (zero for an empty list) by a bitwise radix select: 64 passes over the kind's
// list of m entries, one list entry read per cycle through the single read port of the latency
// list. The twelve results are sent in order, each when its select ends, the last one marked;
// a result waits for the output to be free. The ring and list memories need no clearing: only
// committed records are ever read. Input is taken only while the block is idle.
module stage_latency_percentile_tracker_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [slpt_pkg::ACT_W-1:0]     i_action,
    input  logic [slpt_pkg::STAGE_W-1:0]   i_stage_index,
    input  logic [slpt_pkg::TS_W-1:0]      i_timestamp,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [slpt_pkg::METRIC_W-1:0]  o_metric,
    output logic [slpt_pkg::PSEL_W-1:0]    o_percentile_sel,
    output logic [slpt_pkg::TS_W-1:0]      o_latency_ticks,
    output logic [slpt_pkg::FRAMES_W-1:0]  o_committed_frames,
    output logic                           o_last
);
    import slpt_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_COMMIT = 9'b000000010,
        S_BRD    = 9'b000000100,
        S_BWR    = 9'b000001000,
        S_MUL    = 9'b000010000,
        S_DIV    = 9'b000100000,
        S_SCAN   = 9'b001000000,
        S_BIT    = 9'b010000000,
        S_EMIT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [TS_W-1:0]     r_latch [NUM_STAGES];
    logic [CAP_W-1:0]    r_wp;
    logic [CNT_W-1:0]    r_vcnt;
    logic [STG_W-1:0]    r_sidx;
    logic [CNT_W-1:0]    r_rec;
    logic [CAP_W-1:0]    r_slot;
    logic [2:0]          r_rd;
    logic [TS_W-1:0]     r_rw [6];
    logic [1:0]          r_k;
    logic [PSEL_W-1:0]   r_p;
    logic [CNT_W-1:0]    r_len [NUM_KINDS];
    logic [X_W-1:0]      r_x;
    logic [CNT_W-1:0]    r_target;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_j;
    logic                r_dv;
    logic [TS_W-1:0]     r_prefix;
    logic [TS_W-1:0]     r_mask;
    logic [TS_W-1:0]     r_bsel;

    logic                r_out_valid;
    logic [METRIC_W-1:0] r_metric;
    logic [PSEL_W-1:0]   r_psel;
    logic [TS_W-1:0]     r_lat;
    logic [FRAMES_W-1:0] r_frames;
    logic                r_last;

    logic                 in_xfer;
    logic                 ring_we, ring_re, buf_we, buf_re;
    logic [RING_AW-1:0]   ring_waddr, ring_raddr;
    logic [BUF_AW-1:0]    buf_waddr, buf_raddr;
    logic [TS_W-1:0]      ring_rdata, buf_rdata;
    logic [TS_W-1:0]      later, earlier;
    logic                 lat_ok;
    logic [CNT_W-1:0]     cur_len;
    logic [X_W+RECIP_W-1:0] prod;
    logic [CNT_W-1:0]     idx_raw;
    logic                 is_last;
    logic                 out_free;
    logic                 take_one;
    logic                 hit;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign cur_len    = r_len[r_k];
    assign out_free   = !r_out_valid || i_out_ready;
    assign is_last    = (r_k == MET_TOTAL) && (r_p == PSEL_P99);

    always_comb begin
        unique case (r_k)
            2'd0: begin later = r_rw[1]; earlier = r_rw[0]; end
            2'd1: begin later = r_rw[3]; earlier = r_rw[2]; end
            2'd2: begin later = r_rw[4]; earlier = r_rw[3]; end
            default: begin later = r_rw[4]; earlier = r_rw[5]; end
        endcase
    end
    assign lat_ok = later > earlier;

    assign prod    = r_x * RECIP;
    assign idx_raw = prod[RECIP_S +: CNT_W];
    assign take_one = r_target >= r_cnt;
    assign hit = r_dv && (((buf_rdata ^ r_prefix) & r_mask) == '0)
                 && !(|(buf_rdata & r_bsel));

    assign ring_we    = (r_state == S_COMMIT);
    assign ring_waddr = RING_AW'(RING_AW'(r_wp) * RING_AW'(NUM_STAGES)) + RING_AW'(r_sidx);
    assign ring_re    = (r_state == S_BRD) && (r_rd < 3'd6);
    assign ring_raddr = RING_AW'(RING_AW'(r_slot) * RING_AW'(NUM_STAGES)) + RING_AW'(r_rd);

    assign buf_we    = (r_state == S_BWR) && lat_ok;
    assign buf_waddr = BUF_AW'(BUF_AW'(r_k) * BUF_AW'(CAPACITY)) + BUF_AW'(cur_len[CAP_W-1:0]);
    assign buf_re    = (r_state == S_SCAN) && (r_j < cur_len);
    assign buf_raddr = BUF_AW'(BUF_AW'(r_k) * BUF_AW'(CAPACITY)) + BUF_AW'(r_j[CAP_W-1:0]);

    slpt_ram #(.WIDTH(TS_W), .DEPTH(RING_D)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (r_latch[r_sidx]),
        .i_re    (ring_re),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    slpt_ram #(.WIDTH(TS_W), .DEPTH(BUF_D)) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (later - earlier),
        .i_re    (buf_re),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && i_action == ACT_COMMIT) begin
                    n_state = S_COMMIT;
                end else if (in_xfer && i_action == ACT_QUERY) begin
                    n_state = (r_vcnt == '0) ? S_MUL : S_BRD;
                end
            end
            S_COMMIT: begin
                if (r_sidx == STG_W'(NUM_STAGES - 1)) n_state = S_IDLE;
            end
            S_BRD: begin
                if (r_rd == 3'd6) n_state = S_BWR;
            end
            S_BWR: begin
                if (r_k == 2'd3) begin
                    n_state = (r_rec + CNT_W'(1) == r_vcnt) ? S_MUL : S_BRD;
                end
            end
            S_MUL: n_state = (cur_len == '0) ? S_EMIT : S_DIV;
            S_DIV: n_state = S_SCAN;
            S_SCAN: begin
                if (r_j == cur_len && !r_dv) n_state = S_BIT;
            end
            S_BIT: n_state = r_bsel[0] ? S_EMIT : S_SCAN;
            S_EMIT: begin
                if (out_free) n_state = is_last ? S_IDLE : S_MUL;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_vcnt      <= '0;
            r_sidx      <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < NUM_STAGES; s++) begin
                r_latch[s] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_EMIT && out_free) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && i_action == ACT_LATCH
                        && 32'(i_stage_index) < NUM_STAGES) begin
                        r_latch[STG_W'(i_stage_index)] <= i_timestamp;
                    end
                    r_sidx <= '0;
                    r_rec  <= '0;
                    r_rd   <= '0;
                    r_k    <= '0;
                    r_p    <= PSEL_P50;
                    r_slot <= (r_vcnt < CNT_W'(CAPACITY)) ? '0 : r_wp;
                    for (int k = 0; k < NUM_KINDS; k++) begin
                        r_len[k] <= '0;
                    end
                end
                S_COMMIT: begin
                    r_latch[r_sidx] <= '0;
                    r_sidx <= r_sidx + STG_W'(1);
                    if (r_sidx == STG_W'(NUM_STAGES - 1)) begin
                        r_wp <= (r_wp == CAP_W'(CAPACITY - 1)) ? '0 : r_wp + CAP_W'(1);
                        if (r_vcnt < CNT_W'(CAPACITY)) r_vcnt <= r_vcnt + CNT_W'(1);
                    end
                end
                S_BRD: begin
                    if (r_rd != 3'd0) r_rw[r_rd - 3'd1] <= ring_rdata;
                    r_rd <= r_rd + 3'd1;
                end
                S_BWR: begin
                    if (lat_ok) r_len[r_k] <= cur_len + CNT_W'(1);
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_rd   <= '0;
                        r_rec  <= r_rec + CNT_W'(1);
                        r_slot <= (r_slot == CAP_W'(CAPACITY - 1)) ? '0 : r_slot + CAP_W'(1);
                    end
                end
                S_MUL: begin
                    r_x      <= X_W'(cur_len) * X_W'(pct_of(r_p));
                    r_prefix <= '0;
                end
                S_DIV: begin
                    r_target <= (idx_raw > cur_len - CNT_W'(1)) ? cur_len - CNT_W'(1) : idx_raw;
                    r_mask   <= '0;
                    r_bsel   <= {1'b1, {(TS_W-1){1'b0}}};
                    r_j      <= '0;
                    r_cnt    <= '0;
                    r_dv     <= 1'b0;
                end
                S_SCAN: begin
                    if (r_j < cur_len) r_j <= r_j + CNT_W'(1);
                    r_dv <= (r_j < cur_len);
                    if (hit) r_cnt <= r_cnt + CNT_W'(1);
                end
                S_BIT: begin
                    if (take_one) begin
                        r_target <= r_target - r_cnt;
                        r_prefix <= r_prefix | r_bsel;
                    end
                    r_mask <= {1'b1, r_mask[TS_W-1:1]};
                    r_bsel <= r_bsel >> 1;
                    r_j    <= '0;
                    r_cnt  <= '0;
                    r_dv   <= 1'b0;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_metric    <= r_k;
                        r_psel      <= r_p;
                        r_lat       <= r_prefix;
                        r_frames    <= FRAMES_W'(r_vcnt);
                        r_last      <= is_last;
                        if (r_p == PSEL_P99) begin
                            r_p <= PSEL_P50;
                            r_k <= r_k + 2'd1;
                        end else begin
                            r_p <= r_p + PSEL_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_metric           = r_metric;
    assign o_percentile_sel   = r_psel;
    assign o_latency_ticks    = r_lat;
    assign o_committed_frames = r_frames;
    assign o_last             = r_last;

`ifndef SYNTHESIS
    a_vcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt <= CNT_W'(CAPACITY))
        else $error("committed count above capacity");
    a_target_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_target < cur_len))
        else $error("select target outside latency list");
    a_last_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_metric == MET_TOTAL && o_percentile_sel == PSEL_P99))
        else $error("last mark on wrong result");
    a_commit_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && r_sidx == STG_W'(NUM_STAGES - 1) && r_vcnt != CNT_W'(CAPACITY))
        |=> (r_vcnt == $past(r_vcnt) + CNT_W'(1)))
        else $error("commit did not advance count");
`endif
endmodule
